// ===== design/pre_pkg.sv =====
// ----------------------------------------------------------------------------
// pre_pkg
// Types, constants and address map of the paged RAM expansion.
// ----------------------------------------------------------------------------
package pre_pkg;

   // Store size; a power of two so that the window index wraps by truncation.
   localparam int MEMORY_KB      = 4096;
   localparam int STORE_BYTES    = MEMORY_KB * 1024;
   localparam int STORE_ADDR_W   = $clog2(STORE_BYTES);
   localparam int WINDOW_INDEX_W = 22;

   localparam logic [15:0] WINDOW_LO = 16'hfe00;
   localparam logic [15:0] WINDOW_HI = 16'hfe7f;
   localparam logic [15:0] REG_BASE  = 16'hfde8;
   localparam logic [15:0] REG_LAST  = 16'hfdea;
   localparam logic [15:0] STATUS_LO = 16'hfd90;
   localparam logic [15:0] STATUS_HI = 16'hfd97;

   localparam logic [5:0] PAGE_MASK         = 6'd63;
   localparam logic [3:0] BLOCK_COUNT_RESET = 4'd8;
   localparam logic [3:0] BLOCK_COUNT_FULL  = 4'd8;
   localparam logic [1:0] RESET_CLEAR_COUNT = 2'd3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      CSR_BLOCK_COUNT_LOG2 = 1'b0
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_PAGE  = 2'd0,
      SEL_BLOCK = 2'd1,
      SEL_HALF  = 2'd2
   } sel_reg_type;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        reset_asserted;
      logic        bus_available;
   } req_item_type;

   typedef struct packed {
      logic                    read_en;
      logic                    write_en;
      logic [STORE_ADDR_W-1:0] addr;
      logic [7:0]              wdata;
   } store_req_type;

   typedef struct packed {
      logic       drive_bus;
      logic       from_store;
      logic [7:0] reg_data;
   } result_info_type;

endpackage

// ===== design/pre_req_if.sv =====
// ----------------------------------------------------------------------------
// pre_req_if
// Request channel: one host bus access per transfer.
// ----------------------------------------------------------------------------
interface pre_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic        reset_asserted;
   logic        bus_available;

   modport source (
      output valid, opcode, address, write_data, reset_asserted, bus_available,
      input  ready
   );
   modport sink (
      input  valid, opcode, address, write_data, reset_asserted, bus_available,
      output ready
   );
endinterface

// ===== design/pre_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pre_rsp_if
// Response channel: the bus drive flag and read byte of one access.
// ----------------------------------------------------------------------------
interface pre_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_bus;
   logic [7:0] read_data;

   modport source (
      output valid, drive_bus, read_data,
      input  ready
   );
   modport sink (
      input  valid, drive_bus, read_data,
      output ready
   );
endinterface

// ===== design/pre_ram.sv =====
// ----------------------------------------------------------------------------
// pre_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     read_en,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= wdata;
      end
      if (read_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/pre_ctrl.sv =====
// ----------------------------------------------------------------------------
// pre_ctrl
// Address decode, select registers, host reset counter and the
// configuration register. Issues store accesses for window transfers.
// ----------------------------------------------------------------------------
module pre_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  pre_pkg::req_item_type              item,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pre_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pre_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pre_pkg::CSR_DATA_W-1:0]     prdata,
   output pre_pkg::store_req_type             store_req,
   output pre_pkg::result_info_type           info
);

   logic [5:0] page_ff, page_in;
   logic [7:0] block_ff, block_in;
   logic       half_ff, half_in;
   logic [1:0] count_ff, count_in;
   logic [3:0] block_count_ff, block_count_in;

   logic                                  in_window;
   logic                                  in_regs;
   logic                                  in_status;
   logic [1:0]                            reg_offset;
   pre_pkg::sel_reg_type                  reg_sel;
   logic [7:0]                            block_mask;
   logic [pre_pkg::WINDOW_INDEX_W-1:0]    window_index;
   logic                                  csr_write;
   logic                                  csr_hit;

   assign in_window  = (item.address >= pre_pkg::WINDOW_LO) &&
                       (item.address <= pre_pkg::WINDOW_HI);
   assign in_regs    = (item.address >= pre_pkg::REG_BASE) &&
                       (item.address <= pre_pkg::REG_LAST);
   assign in_status  = (item.opcode == pre_pkg::OP_READ) && item.bus_available &&
                       (item.address >= pre_pkg::STATUS_LO) &&
                       (item.address <= pre_pkg::STATUS_HI);
   assign reg_offset = 2'(item.address - pre_pkg::REG_BASE);
   assign reg_sel    = pre_pkg::sel_reg_type'(reg_offset);

   assign block_mask = (block_count_ff >= pre_pkg::BLOCK_COUNT_FULL) ? 8'hff :
                       8'((9'd1 << block_count_ff) - 9'd1);

   assign window_index = {block_ff, page_ff, half_ff, item.address[6:0]};

   assign csr_hit   = (paddr[2] == pre_pkg::CSR_BLOCK_COUNT_LOG2);
   assign csr_write = psel && penable && pwrite;
   assign prdata    = csr_hit ? {28'd0, block_count_ff} : '0;

   always_comb begin
      store_req.read_en  = accept && in_window && (item.opcode == pre_pkg::OP_READ);
      store_req.write_en = accept && in_window && (item.opcode == pre_pkg::OP_WRITE);
      store_req.addr     = window_index[pre_pkg::STORE_ADDR_W-1:0];
      store_req.wdata    = item.write_data;
   end

   always_comb begin
      info.drive_bus  = 1'b0;
      info.from_store = 1'b0;
      info.reg_data   = 8'd0;
      if (in_window) begin
         info.drive_bus  = (item.opcode == pre_pkg::OP_READ);
         info.from_store = (item.opcode == pre_pkg::OP_READ);
      end else if (in_regs) begin
         if (item.opcode == pre_pkg::OP_READ) begin
            info.drive_bus = 1'b1;
            unique case (reg_sel)
               pre_pkg::SEL_PAGE:  info.reg_data = {2'd0, page_ff};
               pre_pkg::SEL_BLOCK: info.reg_data = block_ff;
               pre_pkg::SEL_HALF:  info.reg_data = {half_ff, 7'd0};
               default:            info.reg_data = 8'd0;
            endcase
         end
      end else if (in_status) begin
         info.drive_bus = 1'b1;
         info.reg_data  = 8'(item.address - pre_pkg::STATUS_LO) + 8'd1;
      end
   end

   always_comb begin
      page_in        = page_ff;
      block_in       = block_ff;
      half_in        = half_ff;
      count_in       = count_ff;
      block_count_in = block_count_ff;
      if (csr_write && csr_hit) begin
         block_count_in = pwdata[3:0];
      end
      if (accept) begin
         if (in_regs && !in_window && (item.opcode == pre_pkg::OP_WRITE)) begin
            unique case (reg_sel)
               pre_pkg::SEL_PAGE:  page_in  = item.write_data[5:0] & pre_pkg::PAGE_MASK;
               pre_pkg::SEL_BLOCK: block_in = item.write_data & block_mask;
               pre_pkg::SEL_HALF:  half_in  = item.write_data[7];
               default:            page_in  = page_ff;
            endcase
         end
         if (item.reset_asserted) begin
            if (count_ff == pre_pkg::RESET_CLEAR_COUNT) begin
               count_in = 2'd0;
               page_in  = 6'd0;
               block_in = 8'd0;
               half_in  = 1'b0;
            end else begin
               count_in = count_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff        <= 6'd0;
         block_ff       <= 8'd0;
         half_ff        <= 1'b0;
         count_ff       <= 2'd0;
         block_count_ff <= pre_pkg::BLOCK_COUNT_RESET;
      end else begin
         page_ff        <= page_in;
         block_ff       <= block_in;
         half_ff        <= half_in;
         count_ff       <= count_in;
         block_count_ff <= block_count_in;
      end
   end

endmodule

// ===== design/pre_store.sv =====
// ----------------------------------------------------------------------------
// pre_store
// Expansion byte store with the zero-fill pass that runs after reset.
// ----------------------------------------------------------------------------
module pre_store (
   input  logic                   clock,
   input  logic                   reset,
   input  pre_pkg::store_req_type store_req,
   output logic                   busy,
   output logic [7:0]             rdata
);

   logic                             clearing_ff, clearing_in;
   logic [pre_pkg::STORE_ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   logic                             ram_read_en;
   logic                             ram_write_en;
   logic [pre_pkg::STORE_ADDR_W-1:0] ram_addr;
   logic [7:0]                       ram_wdata;

   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + pre_pkg::STORE_ADDR_W'(1);
         if (clear_addr_ff == pre_pkg::STORE_ADDR_W'(pre_pkg::STORE_BYTES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_comb begin
      if (clearing_ff) begin
         ram_read_en  = 1'b0;
         ram_write_en = 1'b1;
         ram_addr     = clear_addr_ff;
         ram_wdata    = 8'd0;
      end else begin
         ram_read_en  = store_req.read_en;
         ram_write_en = store_req.write_en;
         ram_addr     = store_req.addr;
         ram_wdata    = store_req.wdata;
      end
   end

   pre_ram #(
      .WIDTH (8),
      .DEPTH (pre_pkg::STORE_BYTES)
   ) u_ram (
      .clock    (clock),
      .read_en  (ram_read_en),
      .write_en (ram_write_en),
      .addr     (ram_addr),
      .wdata    (ram_wdata),
      .rdata    (rdata)
   );

   assign busy = clearing_ff;

endmodule

// ===== design/pre_out.sv =====
// ----------------------------------------------------------------------------
// pre_out
// Result path: a stage that waits for the store read data, then the
// output register that holds a transfer until the receiver takes it.
// ----------------------------------------------------------------------------
module pre_out (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  pre_pkg::result_info_type info,
   input  logic [7:0]               store_rdata,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_drive_bus,
   output logic [7:0]               rsp_read_data,
   output logic                     in_ready
);

   logic                     s1_valid_ff, s1_valid_in;
   pre_pkg::result_info_type s1_info_ff;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_drive_ff;
   logic [7:0]               out_data_ff;
   logic                     move;

   assign move     = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign in_ready = !s1_valid_ff || move;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
      if (move) begin
         out_drive_ff <= s1_info_ff.drive_bus;
         out_data_ff  <= s1_info_ff.from_store ? store_rdata : s1_info_ff.reg_data;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_drive_bus = out_drive_ff;
   assign rsp_read_data = out_data_ff;

endmodule

// ===== design/paged_ram_expansion.sv =====
// ----------------------------------------------------------------------------
// paged_ram_expansion
// Banked RAM expansion seen by a host bus through a 128-byte window.
// ----------------------------------------------------------------------------
// Each transfer on req is one host bus access: opcode, address, write byte,
// the host reset line and the bus available flag. Each access gives exactly
// one transfer on rsp with the drive flag and the read byte (zero when the
// block does not drive the bus).
// The store read is registered in the synchronous RAM together with the
// stage in front of the output, then the result is registered at the output.
// One access is taken every cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its transfer and one
// more access is taken into the stage in front of it; req.ready then falls
// until the output drains.
// After reset the store is filled with zeros one byte a cycle; req.ready
// stays low until the fill pass ends. The configuration register can be
// written throughout.
// ----------------------------------------------------------------------------
module paged_ram_expansion (
   input  logic                           clock,
   input  logic                           reset,
   pre_req_if.sink                        req,
   pre_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pre_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pre_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pre_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   pre_pkg::req_item_type    item;
   pre_pkg::store_req_type   store_req;
   pre_pkg::result_info_type info;
   logic                     busy;
   logic [7:0]               store_rdata;
   logic                     out_ready;
   logic                     accept;

   assign item.opcode         = req.opcode;
   assign item.address        = req.address;
   assign item.write_data     = req.write_data;
   assign item.reset_asserted = req.reset_asserted;
   assign item.bus_available  = req.bus_available;

   assign req.ready = out_ready && !busy;
   assign accept    = req.valid && req.ready;
   assign pready    = 1'b1;

   pre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .store_req (store_req),
      .info      (info)
   );

   pre_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .busy      (busy),
      .rdata     (store_rdata)
   );

   pre_out u_out (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .info          (info),
      .store_rdata   (store_rdata),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_drive_bus (rsp.drive_bus),
      .rsp_read_data (rsp.read_data),
      .in_ready      (out_ready)
   );

`ifndef SYNTHESIS
   a_no_access_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !req.ready)
      else $error("Access taken before the store fill pass.");

   a_idle_bus_reads_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.drive_bus) |-> (rsp.read_data == 8'd0))
      else $error("Read byte not zero while the bus is not driven.");

   a_store_read_on_transfer : assert property (@(posedge clock) disable iff (reset)
      store_req.read_en |-> (req.valid && !busy))
      else $error("Store read issued without a request transfer.");
`endif

endmodule
